FILE: hdl/lhe_pkg.sv
// shared types, constants and helpers for the led hsl effect generator
package lhe_pkg;

	localparam int SIZE_W = 16;
	localparam int CFG_W = 16;
	localparam int IDX_W = 3;

	localparam int TICKS_PER_K = 1000;
	localparam int HUE_DEG = 360;
	localparam int LVL_DEN = 255;

	// Q0.16 constants, one extra bit so unity itself fits
	localparam logic [16:0] UNITY = 17'h10000;
	localparam logic [16:0] HALF = 17'h08000;
	localparam logic [16:0] THIRD = 17'd21845;
	localparam logic [16:0] TWO_THIRDS = 17'd43690;

	typedef enum logic [IDX_W-1:0] {
		REG_MODE,
		REG_FRAME_SIZE,
		REG_BASE_HUE,
		REG_SATURATION,
		REG_LIGHTNESS,
		REG_HUE_RATE,
		REG_SECOND_RATE,
		REG_DUTY
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SPARK_ASYNC,
		MODE_SPARK_SYNC,
		MODE_METEOR_ASYNC,
		MODE_METEOR_SYNC
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [SIZE_W-1:0] frame_size;
		logic [7:0]        base_hue;
		logic [7:0]        saturation;
		logic [7:0]        lightness;
		logic [7:0]        hue_rate;
		logic [7:0]        second_rate;
		logic [7:0]        duty;
	} cfg_t;

	function automatic logic [7:0] clamp_level(input logic [9:0] v, input logic [7:0] lo,
		input logic [7:0] hi);
		logic [7:0] res;
		if (v < {2'b00, lo}) begin
			res = lo;
		end else if (v > {2'b00, hi}) begin
			res = hi;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

FILE: hdl/lhe_tick_if.sv
// tick input channel
interface lhe_tick_if #(
	parameter int TICK_BITS = 24
) ();
	logic                 valid;
	logic                 ready;
	logic [TICK_BITS-1:0] tick;

	modport source (output valid, tick, input ready);
	modport sink (input valid, tick, output ready);
endinterface

FILE: hdl/lhe_color_if.sv
// rgb result channel
interface lhe_color_if ();
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, red, green, blue, input ready);
	modport sink (input valid, red, green, blue, output ready);
endinterface

FILE: hdl/lhe_div.sv
// pipelined restoring divider, one quotient bit per stage
module lhe_div
	import lhe_pkg::*;
#(
	parameter int NB = 16,
	parameter int SW = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              vld_in,
	input  logic [SIZE_W-1:0] rem_in,
	input  logic [NB-1:0]     num_in,
	input  logic [SIZE_W-1:0] den,
	input  logic [SW-1:0]     side_in,
	output logic              vld_out,
	output logic [NB-1:0]     quo,
	output logic [SIZE_W-1:0] rem,
	output logic [SW-1:0]     side_out
);

	logic              vld_s  [NB];
	logic [SIZE_W-1:0] rem_s  [NB];
	logic [NB-1:0]     num_s  [NB];
	logic [NB-1:0]     quo_s  [NB];
	logic [SW-1:0]     side_s [NB];

	for (genvar k = 0; k < NB; k++) begin : g_stage
		logic              vld_p;
		logic [SIZE_W-1:0] rem_p;
		logic [NB-1:0]     num_p;
		logic [NB-1:0]     quo_p;
		logic [SW-1:0]     side_p;
		logic [SIZE_W:0]   trial;
		logic              fits;

		if (k == 0) begin : g_head
			assign vld_p = vld_in;
			assign rem_p = rem_in;
			assign num_p = num_in;
			assign quo_p = '0;
			assign side_p = side_in;
		end else begin : g_body
			assign vld_p = vld_s[k-1];
			assign rem_p = rem_s[k-1];
			assign num_p = num_s[k-1];
			assign quo_p = quo_s[k-1];
			assign side_p = side_s[k-1];
		end

		// shift the next dividend bit into the partial remainder
		assign trial = {rem_p, num_p[NB-1]};
		assign fits = trial >= {1'b0, den};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_p;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= fits ? SIZE_W'(trial - {1'b0, den}) : trial[SIZE_W-1:0];
				num_s[k] <= num_p << 1;
				quo_s[k] <= (quo_p << 1) | NB'(fits);
				side_s[k] <= side_p;
			end
		end
	end

	assign vld_out = vld_s[NB-1];
	assign quo = quo_s[NB-1];
	assign rem = rem_s[NB-1];
	assign side_out = side_s[NB-1];

endmodule

FILE: hdl/lhe_cdiv.sv
// division by a constant: registered reciprocal estimate, then one correction step
module lhe_cdiv #(
	parameter int W = 16,
	parameter int D = 1000,
	parameter int SW = 1,
	localparam int RW = $clog2(D)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          vld_in,
	input  logic [W-1:0]  num,
	input  logic [SW-1:0] side_in,
	output logic          vld_out,
	output logic [W-1:0]  quo,
	output logic [RW-1:0] rem,
	output logic [SW-1:0] side_out
);

	localparam longint unsigned RECIP = (64'd1 << W) / D;
	localparam logic [W-1:0] RCP = W'(RECIP);
	localparam logic [W-1:0] DIV = W'(D);

	logic [2*W-1:0] prod;
	logic           vld_s1;
	logic [W-1:0]   num_s1;
	logic [W-1:0]   est_s1;
	logic [SW-1:0]  side_s1;
	logic [W-1:0]   back;
	logic [W-1:0]   resid;
	logic           over;

	// estimate is the true quotient or one below it
	assign prod = {{W{1'b0}}, num} * {{W{1'b0}}, RCP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1 <= num;
			est_s1 <= prod[2*W-1:W];
			side_s1 <= side_in;
		end
	end

	assign back = est_s1 * DIV;
	assign resid = num_s1 - back;
	assign over = resid >= DIV;

	assign vld_out = vld_s1;
	assign quo = est_s1 + W'(over);
	assign rem = over ? RW'(resid - DIV) : RW'(resid);
	assign side_out = side_s1;

endmodule

FILE: hdl/lhe_hsl.sv
// hsl to rgb conversion in Q0.16, truncation to 8 bits and clamp
module lhe_hsl
	import lhe_pkg::*;
#(
	parameter int LO = 0,
	parameter int HI = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  cfg_t       cfg,
	input  logic       vld_in,
	input  logic [8:0] hue,
	input  logic [7:0] lnum,
	input  logic [15:0] lmet,
	input  logic       blank,
	output logic       vld_out,
	output logic [7:0] chan [3]
);

	localparam int NCH = 3;
	localparam logic [7:0] LO8 = 8'(LO);
	localparam logic [7:0] HI8 = 8'(HI);

	typedef enum logic [1:0] {SEG_RISE, SEG_HIGH, SEG_FALL, SEG_LOW} seg_t;

	logic        meteor;
	logic        vld_h;
	logic [24:0] hquo_h;
	logic [24:0] side_h;
	logic [7:0]  lnum_h;
	logic [15:0] lmet_h;
	logic        blank_h;

	assign meteor = (cfg.mode == MODE_METEOR_ASYNC) || (cfg.mode == MODE_METEOR_SYNC);

	// hue degrees to Q0.16
	lhe_cdiv #(.W(25), .D(HUE_DEG), .SW(25)) u_hdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vld_in   (vld_in),
		.num      ({hue, 16'd0}),
		.side_in  ({lnum, lmet, blank}),
		.vld_out  (vld_h),
		.quo      (hquo_h),
		.rem      (),
		.side_out (side_h)
	);

	assign {lnum_h, lmet_h, blank_h} = side_h;

	logic        vld_c1, vld_c2, vld_c3, vld_c4, vld_c5, vld_c6;
	logic        blank_c1, blank_c2, blank_c3, blank_c4, blank_c5;
	logic [15:0] l_c1, l_c2;
	logic [16:0] s_c1, s_c2;
	logic [32:0] ls_c2;
	logic [16:0] t_c1 [NCH];
	logic [16:0] t_c2 [NCH];
	logic [16:0] t_c3 [NCH];
	logic [16:0] v1_c3, v2_c3, d_c3;
	logic [16:0] v1_c4, v2_c4, d_c4;
	logic [16:0] v1_c5, v2_c5;
	seg_t        seg_c4 [NCH];
	seg_t        seg_c5 [NCH];
	logic [15:0] f_c4 [NCH];
	logic [32:0] p_c5 [NCH];
	logic [7:0]  chan_c6 [NCH];

	logic [15:0] hval;
	logic [16:0] ls;
	logic [17:0] v2_wide;
	logic [16:0] v2, v1, twol;

	assign hval = hquo_h[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c1 <= 1'b0;
			vld_c2 <= 1'b0;
			vld_c3 <= 1'b0;
			vld_c4 <= 1'b0;
			vld_c5 <= 1'b0;
			vld_c6 <= 1'b0;
		end else if (en) begin
			vld_c1 <= vld_h;
			vld_c2 <= vld_c1;
			vld_c3 <= vld_c2;
			vld_c4 <= vld_c3;
			vld_c5 <= vld_c4;
			vld_c6 <= vld_c5;
		end
	end

	// v2 from one shared l*s product
	assign ls = ls_c2[32:16];
	assign v2_wide = ({2'b00, l_c2} < {1'b0, HALF}) ? {2'b00, l_c2} + {1'b0, ls}
		: {2'b00, l_c2} + {1'b0, s_c2} - {1'b0, ls};
	assign v2 = v2_wide[16:0];
	assign twol = {l_c2, 1'b0};
	assign v1 = (twol > v2) ? twol - v2 : 17'd0;

	always_ff @(posedge clk) begin
		if (en) begin
			l_c1 <= meteor ? lmet_h : {lnum_h, lnum_h};
			s_c1 <= (cfg.saturation == 8'hFF) ? UNITY : {1'b0, cfg.saturation, cfg.saturation};
			blank_c1 <= blank_h;

			ls_c2 <= {17'd0, l_c1} * {16'd0, s_c1};
			l_c2 <= l_c1;
			s_c2 <= s_c1;
			blank_c2 <= blank_c1;

			v1_c3 <= v1;
			v2_c3 <= v2;
			d_c3 <= v2 - v1;
			blank_c3 <= blank_c2;

			v1_c4 <= v1_c3;
			v2_c4 <= v2_c3;
			d_c4 <= d_c3;
			blank_c4 <= blank_c3;

			v1_c5 <= v1_c4;
			v2_c5 <= v2_c4;
			blank_c5 <= blank_c4;
		end
	end

	for (genvar c = 0; c < NCH; c++) begin : g_chan
		logic [16:0] tw;
		logic [16:0] hsum;
		logic [19:0] six_t;
		logic [18:0] three_t;
		logic [19:0] fall_f;
		seg_t        seg;
		logic [15:0] f;
		logic [16:0] inc;
		logic [17:0] cval;
		logic [25:0] scaled;

		assign hsum = {1'b0, hval} + THIRD;

		// red leads by a third, blue lags by a third, wrapped into one turn
		if (c == 0) begin : g_red
			assign tw = (hsum > UNITY) ? hsum - UNITY : hsum;
		end else if (c == 1) begin : g_green
			assign tw = {1'b0, hval};
		end else begin : g_blue
			assign tw = ({1'b0, hval} < THIRD) ? {1'b0, hval} + UNITY - THIRD
				: {1'b0, hval} - THIRD;
		end

		assign six_t = {t_c3[c], 2'b00} + {1'b0, t_c3[c], 1'b0};
		assign three_t = {1'b0, t_c3[c], 1'b0} + {2'b00, t_c3[c]};
		assign fall_f = 20'((TWO_THIRDS - t_c3[c]) * 6);

		always_comb begin
			if (six_t < {3'b000, UNITY}) begin
				seg = SEG_RISE;
				f = six_t[15:0];
			end else if (t_c3[c] < HALF) begin
				seg = SEG_HIGH;
				f = 16'd0;
			end else if (three_t < {1'b0, UNITY, 1'b0}) begin
				seg = SEG_FALL;
				f = fall_f[15:0];
			end else begin
				seg = SEG_LOW;
				f = 16'd0;
			end
		end

		assign inc = p_c5[c][32:16];

		always_comb begin
			case (seg_c5[c])
				SEG_RISE, SEG_FALL: cval = {1'b0, v1_c5} + {1'b0, inc};
				SEG_HIGH: cval = {1'b0, v2_c5};
				SEG_LOW: cval = {1'b0, v1_c5};
				default: cval = {1'b0, v1_c5};
			endcase
		end

		// c * 255 / 65536
		assign scaled = {cval, 8'd0} - {8'd0, cval};

		always_ff @(posedge clk) begin
			if (en) begin
				t_c1[c] <= tw;
				t_c2[c] <= t_c1[c];
				t_c3[c] <= t_c2[c];
				seg_c4[c] <= seg;
				f_c4[c] <= f;
				seg_c5[c] <= seg_c4[c];
				p_c5[c] <= {16'd0, d_c4} * {17'd0, f_c4[c]};
				chan_c6[c] <= blank_c5 ? clamp_level(10'd0, LO8, HI8)
					: clamp_level(scaled[25:16], LO8, HI8);
			end
		end

		assign chan[c] = chan_c6[c];
	end

	assign vld_out = vld_c6;

endmodule

FILE: hdl/led_hsl_effect_generator_top.sv
// led hsl effect generator: one tick in, one clamped rgb colour out
//
// ticks carries one time index per transfer; colors carries the resulting
// red, green and blue levels, one transfer per accepted tick, in order.
// Registers are written through cfg_we / cfg_idx / cfg_data; the user must
// write them only while no tick is in flight, which the block does not
// enforce. The index follows mode, frame_size, base_hue, saturation,
// lightness, hue_rate, second_rate, duty. The phase divider (one stage
// per tick bit) and the 16-stage meteor lightness divider make up most
// of the pipeline.
// Throughput is one tick per cycle while colors is taken every cycle.
// Reset empties the pipeline and loads the default register values.
// When the receiver holds off, the whole pipeline freezes and ticks.ready
// drops in the same cycle; nothing is dropped or repeated.
module led_hsl_effect_generator_top
	import lhe_pkg::*;
#(
	parameter int CLAMP_LOW = 0,
	parameter int CLAMP_HIGH = 255,
	parameter int TICK_BITS = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	lhe_tick_if.sink         ticks,
	lhe_color_if.source      colors,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int T = TICK_BITS;
	localparam int KR_W = $clog2(TICKS_PER_K);
	localparam cfg_t CFG_RESET = '{
		mode: MODE_SPARK_ASYNC,
		frame_size: 16'd1000,
		base_hue: 8'd0,
		saturation: 8'd255,
		lightness: 8'd128,
		hue_rate: 8'd0,
		second_rate: 8'd0,
		duty: 8'd255
	};

	cfg_t cfg_q;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_MODE: cfg_q.mode <= mode_t'(cfg_data[1:0]);
				REG_FRAME_SIZE: cfg_q.frame_size <= cfg_data[SIZE_W-1:0];
				REG_BASE_HUE: cfg_q.base_hue <= cfg_data[7:0];
				REG_SATURATION: cfg_q.saturation <= cfg_data[7:0];
				REG_LIGHTNESS: cfg_q.lightness <= cfg_data[7:0];
				REG_HUE_RATE: cfg_q.hue_rate <= cfg_data[7:0];
				REG_SECOND_RATE: cfg_q.second_rate <= cfg_data[7:0];
				REG_DUTY: cfg_q.duty <= cfg_data[7:0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// the pipeline moves as one unless the output register is held
	assign adv = !colors.valid || colors.ready;
	assign ticks.ready = adv;

	// phase = tick mod frame_size
	logic              vld_d1;
	logic [SIZE_W-1:0] phase_d1;
	logic [T-1:0]      tick_d1;

	lhe_div #(.NB(T), .SW(T)) u_phase_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (ticks.valid),
		.rem_in   ('0),
		.num_in   (ticks.tick),
		.den      (cfg_q.frame_size),
		.side_in  (ticks.tick),
		.vld_out  (vld_d1),
		.quo      (),
		.rem      (phase_d1),
		.side_out (tick_d1)
	);

	// 255*phase/size >= duty  <=>  255*phase >= duty*size
	logic              vld_s1, blank_s1;
	logic [SIZE_W-1:0] phase_s1;
	logic [T-1:0]      x_s1, y_s1;
	logic [23:0]       scaled_phase, duty_lim;

	assign scaled_phase = {phase_d1, 8'd0} - {8'd0, phase_d1};
	assign duty_lim = {16'd0, cfg_q.duty} * {8'd0, cfg_q.frame_size};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vld_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			phase_s1 <= phase_d1;
			blank_s1 <= (cfg_q.frame_size == '0) || (scaled_phase >= duty_lim);
			x_s1 <= (cfg_q.mode == MODE_SPARK_SYNC) ? T'(phase_d1) : tick_d1;
			y_s1 <= (cfg_q.mode == MODE_SPARK_ASYNC) ? tick_d1 : T'(phase_d1);
		end
	end

	// meteor lightness = phase * 65536 / size
	logic              vld_d2;
	logic [SIZE_W-1:0] lm_d2;
	logic [2*T:0]      side_d2;
	logic              blank_d2;
	logic [T-1:0]      x_d2, y_d2;

	lhe_div #(.NB(SIZE_W), .SW(2*T+1)) u_light_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s1),
		.rem_in   (phase_s1),
		.num_in   ('0),
		.den      (cfg_q.frame_size),
		.side_in  ({blank_s1, x_s1, y_s1}),
		.vld_out  (vld_d2),
		.quo      (lm_d2),
		.rem      (),
		.side_out (side_d2)
	);

	assign {blank_d2, x_d2, y_d2} = side_d2;

	// split both time bases into thousands and remainder
	logic              vld_kx;
	logic [T-1:0]      qx_k, qy_k;
	logic [KR_W-1:0]   rx_k, ry_k;
	logic [SIZE_W:0]   side_kx;
	logic              side_ky;

	lhe_cdiv #(.W(T), .D(TICKS_PER_K), .SW(SIZE_W+1)) u_kx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_d2),
		.num      (x_d2),
		.side_in  ({blank_d2, lm_d2}),
		.vld_out  (vld_kx),
		.quo      (qx_k),
		.rem      (rx_k),
		.side_out (side_kx)
	);

	lhe_cdiv #(.W(T), .D(TICKS_PER_K), .SW(1)) u_ky (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_d2),
		.num      (y_d2),
		.side_in  (blank_d2),
		.vld_out  (),
		.quo      (qy_k),
		.rem      (ry_k),
		.side_out (side_ky)
	);

	logic              vld_s2, blank_s2, vld_s3, blank_s3;
	logic [T-1:0]      qx_s2, qy_s2;
	logic [KR_W-1:0]   rx_s2, ry_s2;
	logic [SIZE_W-1:0] lm_s2, lm_s3;
	logic [T-1:0]      hq_s3, sq_s3;
	logic [17:0]       hr_s3, sr_s3;
	logic [T+7:0]      hq_full, sq_full;

	assign hq_full = {8'd0, qx_s2} * {{T{1'b0}}, cfg_q.hue_rate};
	assign sq_full = {8'd0, qy_s2} * {{T{1'b0}}, cfg_q.second_rate};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_kx;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s2 <= qx_k;
			rx_s2 <= rx_k;
			qy_s2 <= qy_k;
			ry_s2 <= ry_k;
			lm_s2 <= side_kx[SIZE_W-1:0];
			blank_s2 <= side_kx[SIZE_W] | side_ky;

			hq_s3 <= hq_full[T-1:0];
			sq_s3 <= sq_full[T-1:0];
			hr_s3 <= {{(18-KR_W){1'b0}}, rx_s2} * {10'd0, cfg_q.hue_rate};
			sr_s3 <= {{(18-KR_W){1'b0}}, ry_s2} * {10'd0, cfg_q.second_rate};
			lm_s3 <= lm_s2;
			blank_s3 <= blank_s2;
		end
	end

	// fractional thousands of the remainders
	logic                  vld_f;
	logic [17:0]           fx_k, fy_k;
	logic [2*T+SIZE_W:0]   side_f;
	logic                  side_fy;

	lhe_cdiv #(.W(18), .D(TICKS_PER_K), .SW(2*T+SIZE_W+1)) u_fx (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s3),
		.num      (hr_s3),
		.side_in  ({hq_s3, sq_s3, lm_s3, blank_s3}),
		.vld_out  (vld_f),
		.quo      (fx_k),
		.rem      (),
		.side_out (side_f)
	);

	lhe_cdiv #(.W(18), .D(TICKS_PER_K), .SW(1)) u_fy (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s3),
		.num      (sr_s3),
		.side_in  (blank_s3),
		.vld_out  (),
		.quo      (fy_k),
		.rem      (),
		.side_out (side_fy)
	);

	logic              vld_s4, blank_s4, vld_s5, blank_s5;
	logic [7:0]        fx_s4, fy_s4;
	logic [T-1:0]      hq_s4, sq_s4;
	logic [SIZE_W-1:0] lm_s4, lm_s5;
	logic [T-1:0]      hue_sum_s5, lsum_s5;
	logic [T-1:0]      hpart, spart;
	logic              meteor;

	assign meteor = (cfg_q.mode == MODE_METEOR_ASYNC) || (cfg_q.mode == MODE_METEOR_SYNC);
	assign hpart = (cfg_q.mode == MODE_METEOR_SYNC) ? '0 : hq_s4 + T'(fx_s4);
	assign spart = sq_s4 + T'(fy_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_f;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s4 <= fx_k[7:0];
			fy_s4 <= fy_k[7:0];
			{hq_s4, sq_s4, lm_s4} <= side_f[2*T+SIZE_W:1];
			blank_s4 <= side_f[0] | side_fy;

			hue_sum_s5 <= T'(cfg_q.base_hue) + hpart + (meteor ? spart : '0);
			lsum_s5 <= T'(cfg_q.lightness) + spart;
			lm_s5 <= lm_s4;
			blank_s5 <= blank_s4;
		end
	end

	// wrap hue into degrees and spark lightness into 0..254
	logic              vld_m;
	logic [8:0]        hue_m;
	logic [7:0]        ln_m;
	logic [SIZE_W:0]   side_m;
	logic              side_ml;

	lhe_cdiv #(.W(T), .D(HUE_DEG), .SW(SIZE_W+1)) u_hue_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s5),
		.num      (hue_sum_s5),
		.side_in  ({lm_s5, blank_s5}),
		.vld_out  (vld_m),
		.quo      (),
		.rem      (hue_m),
		.side_out (side_m)
	);

	lhe_cdiv #(.W(T), .D(LVL_DEN), .SW(1)) u_light_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.vld_in   (vld_s5),
		.num      (lsum_s5),
		.side_in  (blank_s5),
		.vld_out  (),
		.quo      (),
		.rem      (ln_m),
		.side_out (side_ml)
	);

	logic              vld_s6, blank_s6;
	logic [8:0]        hue_s6;
	logic [7:0]        ln_s6;
	logic [SIZE_W-1:0] lm_s6;
	logic [7:0]        rgb [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s6 <= vld_m;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hue_s6 <= hue_m;
			ln_s6 <= ln_m;
			lm_s6 <= side_m[SIZE_W:1];
			blank_s6 <= side_m[0] | side_ml;
		end
	end

	lhe_hsl #(.LO(CLAMP_LOW), .HI(CLAMP_HIGH)) u_hsl (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.cfg     (cfg_q),
		.vld_in  (vld_s6),
		.hue     (hue_s6),
		.lnum    (ln_s6),
		.lmet    (lm_s6),
		.blank   (blank_s6),
		.vld_out (colors.valid),
		.chan    (rgb)
	);

	assign colors.red = rgb[0];
	assign colors.green = rgb[1];
	assign colors.blue = rgb[2];

endmodule

FILE: hdl/lhe_chk.sv
// port-level checks for the effect generator, bound to the top level
module lhe_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red,
	input logic [7:0] green,
	input logic [7:0] blue
);

	// a stalled colour stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("colour dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
		else $error("colour changed while stalled");

	// a stall at the output freezes the input side in the same cycle
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("tick taken while output stalled");

	// with nothing waiting at the output the block is always ready for a tick
	a_no_idle_block: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

endmodule

bind led_hsl_effect_generator_top lhe_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (ticks.ready),
	.out_valid (colors.valid),
	.out_ready (colors.ready),
	.red       (colors.red),
	.green     (colors.green),
	.blue      (colors.blue)
);
